// ----- rtl/cvr_pkg.sv -----
// Shared constants and control types for the collision velocity response pipeline.
package cvr_pkg;

  localparam int COMPONENT_WIDTH_DEF = 20;
  localparam int MASS_WIDTH_DEF      = 16;
  localparam int FRAC_BITS           = 12;
  localparam int TS_WIDTH            = 16;
  localparam int MASS_FIELD_WIDTH    = 16;
  localparam int VEC_FIELD_WIDTH     = 60;
  localparam logic [TS_WIDTH-1:0] TS_RESET = 16'd1092;

  typedef struct packed {
    logic vld;
    logic plastic;
    logic zmass;
  } ctl_t;

endpackage

// ----- rtl/cvr_front.sv -----
// Front stages: normal speeds by dot product, momentum numerator and divider operand.
module cvr_front #(
  parameter int CW   = 20,
  parameter int MW   = 16,
  parameter int AW   = 2 * CW - 11,
  parameter int NUMW = AW + MW + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cvr_pkg::ctl_t        in_ctl,
  input  logic [MW-1:0]        m1_i,
  input  logic [MW-1:0]        m2_i,
  input  logic [3*CW-1:0]      v_i,
  input  logic [3*CW-1:0]      w_i,
  input  logic [3*CW-1:0]      n_i,
  input  logic [3*CW-1:0]      x_i,
  output cvr_pkg::ctl_t        out_ctl,
  output logic [NUMW:0]        magd_o,
  output logic [MW:0]          msum_o,
  output logic                 neg_o,
  output logic signed [AW-1:0] a_o,
  output logic [3*CW-1:0]      v_o,
  output logic [3*CW-1:0]      n_o,
  output logic [3*CW-1:0]      x_o
);
  import cvr_pkg::*;

  localparam int DW = 2 * CW + 1;
  localparam logic signed [DW-1:0] DOT_RND = DW'(1 << (FRAC_BITS - 1));

  // Stage 1: component products.
  ctl_t                  ctl1_r;
  logic [MW-1:0]         m1_1_r, m2_1_r;
  logic [3*CW-1:0]       v1_r, n1_r, x1_r;
  logic signed [2*CW-1:0] pv_r [3];
  logic signed [2*CW-1:0] pw_r [3];

  // Stage 2: rounded normal speeds and mass terms.
  ctl_t                  ctl2_r;
  logic [MW-1:0]         m2_2_r;
  logic [MW:0]           msum2_r;
  logic signed [MW:0]    dm2_r;
  logic signed [AW-1:0]  a2_r, b2_r;
  logic [3*CW-1:0]       v2_r, n2_r, x2_r;
  logic signed [DW-1:0]  sa, sb;

  // Stage 3: numerator products.
  ctl_t                    ctl3_r;
  logic [MW:0]             msum3_r;
  logic signed [AW-1:0]    a3_r;
  logic signed [AW+MW:0]   ta3_r;
  logic signed [AW+MW+1:0] tb3_r;
  logic [3*CW-1:0]         v3_r, n3_r, x3_r;

  // Stage 4: numerator magnitude plus half the divisor.
  ctl_t                   ctl4_r;
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (en) begin
      ctl1_r <= in_ctl;
      ctl2_r <= '{vld: ctl1_r.vld, plastic: ctl1_r.plastic,
                  zmass: !ctl1_r.plastic && (({1'b0, m1_1_r} + {1'b0, m2_1_r}) == '0)};
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_comb begin
    sa  = DW'(pv_r[0]) + DW'(pv_r[1]) + DW'(pv_r[2]) + DOT_RND;
    sb  = DW'(pw_r[0]) + DW'(pw_r[1]) + DW'(pw_r[2]) + DOT_RND;
    num = NUMW'(ta3_r) + NUMW'(tb3_r);
    mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_1_r <= m1_i;
      m2_1_r <= m2_i;
      v1_r   <= v_i;
      n1_r   <= n_i;
      x1_r   <= x_i;
      for (int k = 0; k < 3; k++) begin
        pv_r[k] <= $signed(n_i[k*CW +: CW]) * $signed(v_i[k*CW +: CW]);
        pw_r[k] <= $signed(n_i[k*CW +: CW]) * $signed(w_i[k*CW +: CW]);
      end

      m2_2_r  <= m2_1_r;
      msum2_r <= {1'b0, m1_1_r} + {1'b0, m2_1_r};
      dm2_r   <= $signed({1'b0, m1_1_r}) - $signed({1'b0, m2_1_r});
      a2_r    <= AW'(sa >>> FRAC_BITS);
      b2_r    <= AW'(sb >>> FRAC_BITS);
      v2_r    <= v1_r;
      n2_r    <= n1_r;
      x2_r    <= x1_r;

      msum3_r <= msum2_r;
      a3_r    <= a2_r;
      ta3_r   <= a2_r * dm2_r;
      tb3_r   <= b2_r * $signed({1'b0, m2_2_r, 1'b0});
      v3_r    <= v2_r;
      n3_r    <= n2_r;
      x3_r    <= x2_r;

      magd_o  <= (NUMW+1)'(mag) + (NUMW+1)'(msum3_r >> 1);
      msum_o  <= msum3_r;
      neg_o   <= num[NUMW-1];
      a_o     <= a3_r;
      v_o     <= v3_r;
      n_o     <= n3_r;
      x_o     <= x3_r;
    end
  end

  assign out_ctl = ctl4_r;

  // An elastic item with a zero mass sum must carry the flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl3_r.vld && !ctl3_r.plastic && (msum3_r == '0) |-> ctl3_r.zmass)
    else $error("zero mass sum not flagged");

endmodule

// ----- rtl/cvr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
module cvr_div #(
  parameter int MW   = 16,
  parameter int QB   = 30,
  parameter int MAGW = 50,
  parameter int SW   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cvr_pkg::ctl_t   in_ctl,
  input  logic [MAGW-1:0] dividend_i,
  input  logic [MW:0]     divisor_i,
  input  logic [SW-1:0]   side_i,
  output cvr_pkg::ctl_t   out_ctl,
  output logic [QB-1:0]   quot_o,
  output logic [SW-1:0]   side_o
);
  import cvr_pkg::*;

  ctl_t          ctl_r  [QB];
  logic [MW:0]   rem_r  [QB];
  logic [QB-1:0] z_r    [QB];
  logic [MW:0]   den_r  [QB];
  logic [SW-1:0] side_r [QB];

  ctl_t          ctl_s  [QB];
  logic [MW:0]   rem_s  [QB];
  logic [QB-1:0] z_s    [QB];
  logic [MW:0]   den_s  [QB];
  logic [SW-1:0] side_s [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [MW+1:0] t;
    logic          ge;

    if (i == 0) begin : g_first
      // The quotient fits in QB bits, so the upper part starts below the divisor.
      assign ctl_s[i]  = in_ctl;
      assign rem_s[i]  = dividend_i[QB +: MW+1];
      assign z_s[i]    = dividend_i[QB-1:0];
      assign den_s[i]  = divisor_i;
      assign side_s[i] = side_i;
    end else begin : g_next
      assign ctl_s[i]  = ctl_r[i-1];
      assign rem_s[i]  = rem_r[i-1];
      assign z_s[i]    = z_r[i-1];
      assign den_s[i]  = den_r[i-1];
      assign side_s[i] = side_r[i-1];
    end

    assign t  = {rem_s[i], z_s[i][QB-1]};
    assign ge = t >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (MW+1)'(t - {1'b0, den_s[i]}) : t[MW:0];
        z_r[i]    <= {z_s[i][QB-2:0], ge};
        den_r[i]  <= den_s[i];
        side_r[i] <= side_s[i];
      end
    end
  end

  assign out_ctl = ctl_r[QB-1];
  assign quot_o  = z_r[QB-1];
  assign side_o  = side_r[QB-1];

  // With a nonzero divisor the final remainder is always reduced.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[QB-1].vld && (den_r[QB-1] != '0) |-> rem_r[QB-1] < den_r[QB-1])
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/cvr_back.sv -----
// Back stages: velocity correction along the normal, saturation and position advance.
module cvr_back #(
  parameter int CW = 20,
  parameter int AW = 2 * CW - 11,
  parameter int QB = AW + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  cvr_pkg::ctl_t               in_ctl,
  input  logic [QB-1:0]               quot_i,
  input  logic                        neg_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic [3*CW-1:0]             v_i,
  input  logic [3*CW-1:0]             n_i,
  input  logic [3*CW-1:0]             x_i,
  input  logic [cvr_pkg::TS_WIDTH-1:0] ts_i,
  output cvr_pkg::ctl_t               out_ctl,
  output logic [3*CW-1:0]             vel_o,
  output logic [3*CW-1:0]             pos_o
);
  import cvr_pkg::*;

  localparam int DDW  = AW + 3;
  localparam int PRW  = CW + DDW;
  localparam int ACCW = PRW + 2;
  localparam int RW   = ACCW - FRAC_BITS;
  localparam int PTW  = CW + TS_WIDTH + 1;
  localparam int STW  = PTW - TS_WIDTH;
  localparam int XW   = CW + 2;
  localparam logic signed [ACCW-1:0] ACC_RND = ACCW'(1 << (FRAC_BITS - 1));
  localparam logic signed [PTW-1:0]  PT_RND  = PTW'(1 << (TS_WIDTH - 1));
  localparam logic signed [CW-1:0]   C_HI    = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]   C_LO    = {1'b1, {(CW-1){1'b0}}};

  ctl_t                   ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic signed [DDW-1:0]  d1_r;
  logic [3*CW-1:0]        v1_r, n1_r, x1_r, v2_r, x2_r, x3_r, x4_r;
  logic signed [PRW-1:0]  pr2_r [3];
  logic signed [CW-1:0]   vn3_r [3];
  logic signed [PTW-1:0]  pt4_r [3];
  logic [3*CW-1:0]        vn4_r;

  logic signed [AW+1:0]   p;
  logic signed [ACCW-1:0] acc  [3];
  logic signed [RW-1:0]   rv   [3];
  logic signed [CW-1:0]   vsat [3];
  logic signed [STW-1:0]  st   [3];
  logic signed [XW-1:0]   xs   [3];
  logic [3*CW-1:0]        pos_nxt;

  always_comb begin
    if (in_ctl.plastic) begin
      p = '0;
    end else if (neg_i) begin
      p = -$signed({1'b0, quot_i});
    end else begin
      p = $signed({1'b0, quot_i});
    end
    for (int k = 0; k < 3; k++) begin
      acc[k] = (ACCW'($signed(v2_r[k*CW +: CW])) <<< FRAC_BITS) + ACCW'(pr2_r[k]) + ACC_RND;
      rv[k]  = RW'(acc[k] >>> FRAC_BITS);
      if (rv[k] > RW'(C_HI)) begin
        vsat[k] = C_HI;
      end else if (rv[k] < RW'(C_LO)) begin
        vsat[k] = C_LO;
      end else begin
        vsat[k] = CW'(rv[k]);
      end
      if (ctl2_r.zmass) begin
        vsat[k] = $signed(v2_r[k*CW +: CW]);
      end

      st[k] = STW'((pt4_r[k] + PT_RND) >>> TS_WIDTH);
      xs[k] = XW'($signed(x4_r[k*CW +: CW])) + XW'(st[k]);
      if (xs[k] > XW'(C_HI)) begin
        pos_nxt[k*CW +: CW] = C_HI;
      end else if (xs[k] < XW'(C_LO)) begin
        pos_nxt[k*CW +: CW] = C_LO;
      end else begin
        pos_nxt[k*CW +: CW] = CW'(xs[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= DDW'(p) - DDW'(a_i);
      v1_r <= v_i;
      n1_r <= n_i;
      x1_r <= x_i;

      for (int k = 0; k < 3; k++) begin
        pr2_r[k] <= $signed(n1_r[k*CW +: CW]) * d1_r;
      end
      v2_r <= v1_r;
      x2_r <= x1_r;

      for (int k = 0; k < 3; k++) begin
        vn3_r[k] <= vsat[k];
      end
      x3_r <= x2_r;

      for (int k = 0; k < 3; k++) begin
        pt4_r[k]            <= vn3_r[k] * $signed({1'b0, ts_i});
        vn4_r[k*CW +: CW]   <= vn3_r[k];
      end
      x4_r <= x3_r;

      vel_o <= vn4_r;
      pos_o <= pos_nxt;
    end
  end

  assign out_ctl = ctl5_r;

  // The zero mass flag only arises on elastic items.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl5_r.vld && ctl5_r.zmass |-> !ctl5_r.plastic)
    else $error("zero mass flag on a plastic item");

endmodule

// ----- rtl/collision_velocity_response.sv -----
// Top level of the collision velocity response pipeline.
//
// Each input beat describes one contact: two Q8.8 masses, own and partner velocity,
// a contact normal and a position (signed Q8.12 components), plus a response kind in
// in_tuser (0 elastic, 1 plastic). One output beat is produced per input beat, in
// order, carrying the new velocity and the advanced position, both saturated per
// component, and in out_tuser a flag that marks an elastic contact whose mass sum is
// zero (its velocity is then passed through unchanged). The block is fully pipelined:
// it takes one beat every cycle unless the output stalls. The pipeline consists of four
// front stages for the dot products and momentum numerator, one restoring divider stage
// per quotient bit (2*COMPONENT_WIDTH-10 stages) and five back stages for the normal
// correction and position update. When the output beat is not taken the whole pipeline
// holds, so in_tready follows out_tready whenever a result is waiting. The time step
// register is written over the cfg port, which is always ready; write it only while no
// beats are in flight.
module collision_velocity_response #(
  parameter int COMPONENT_WIDTH = cvr_pkg::COMPONENT_WIDTH_DEF,
  parameter int MASS_WIDTH      = cvr_pkg::MASS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input beat: own_mass, partner_mass, velocity, partner_velocity, normal, position.
  input  logic [271:0]                  in_tdata,
  // Input tuser: response_kind.
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Output beat: new_velocity, new_position.
  output logic [119:0]                  out_tdata,
  // Output tuser: zero_mass_flag.
  output logic                          out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [cvr_pkg::TS_WIDTH-1:0]  cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);
  import cvr_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int MW   = MASS_WIDTH;
  localparam int VW   = 3 * CW;
  localparam int AW   = 2 * CW - 11;
  localparam int NUMW = AW + MW + 3;
  localparam int MAGW = NUMW + 1;
  localparam int QB   = AW + 1;
  localparam int SW   = 1 + AW + 3 * VW;

  logic [TS_WIDTH-1:0] ts_r;
  logic                en;

  logic [MW-1:0] m1, m2;
  logic [VW-1:0] v_in, w_in, n_in, x_in;

  ctl_t                 in_ctl, f_ctl, d_ctl, b_ctl;
  logic [NUMW:0]        f_magd;
  logic [MW:0]          f_msum;
  logic                 f_neg, d_neg;
  logic signed [AW-1:0] f_a, d_a;
  logic [VW-1:0]        f_v, f_n, f_x, d_v, d_n, d_x;
  logic [QB-1:0]        d_quot;
  logic [SW-1:0]        d_side;
  logic [VW-1:0]        vel, pos;

  // Time step register; configuration is taken at any cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
    end else if (cfg_valid) begin
      ts_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // The pipeline moves whenever the final register is empty or being drained.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign in_ctl = '{vld: in_tvalid, plastic: in_tuser, zmass: 1'b0};

  // Only the low MASS_WIDTH bits of each mass take part.
  if (MW <= MASS_FIELD_WIDTH) begin : g_mass_cut
    assign m1 = in_tdata[MW-1:0];
    assign m2 = in_tdata[MASS_FIELD_WIDTH +: MW];
  end else begin : g_mass_ext
    assign m1 = {{(MW-MASS_FIELD_WIDTH){1'b0}}, in_tdata[15:0]};
    assign m2 = {{(MW-MASS_FIELD_WIDTH){1'b0}}, in_tdata[31:16]};
  end

  // Vector fields: x in the low component, bits beyond the field read as zero.
  if (VW <= VEC_FIELD_WIDTH) begin : g_vec_cut
    assign v_in = in_tdata[32 +: VW];
    assign w_in = in_tdata[92 +: VW];
    assign n_in = in_tdata[152 +: VW];
    assign x_in = in_tdata[212 +: VW];
  end else begin : g_vec_ext
    assign v_in = {{(VW-VEC_FIELD_WIDTH){1'b0}}, in_tdata[91:32]};
    assign w_in = {{(VW-VEC_FIELD_WIDTH){1'b0}}, in_tdata[151:92]};
    assign n_in = {{(VW-VEC_FIELD_WIDTH){1'b0}}, in_tdata[211:152]};
    assign x_in = {{(VW-VEC_FIELD_WIDTH){1'b0}}, in_tdata[271:212]};
  end

  cvr_front #(.CW(CW), .MW(MW), .AW(AW), .NUMW(NUMW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (in_ctl),
    .m1_i    (m1),
    .m2_i    (m2),
    .v_i     (v_in),
    .w_i     (w_in),
    .n_i     (n_in),
    .x_i     (x_in),
    .out_ctl (f_ctl),
    .magd_o  (f_magd),
    .msum_o  (f_msum),
    .neg_o   (f_neg),
    .a_o     (f_a),
    .v_o     (f_v),
    .n_o     (f_n),
    .x_o     (f_x)
  );

  cvr_div #(.MW(MW), .QB(QB), .MAGW(MAGW), .SW(SW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_ctl     (f_ctl),
    .dividend_i (f_magd),
    .divisor_i  (f_msum),
    .side_i     ({f_neg, f_a, f_v, f_n, f_x}),
    .out_ctl    (d_ctl),
    .quot_o     (d_quot),
    .side_o     (d_side)
  );

  assign {d_neg, d_a, d_v, d_n, d_x} = d_side;

  cvr_back #(.CW(CW), .AW(AW), .QB(QB)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (d_ctl),
    .quot_i  (d_quot),
    .neg_i   (d_neg),
    .a_i     (d_a),
    .v_i     (d_v),
    .n_i     (d_n),
    .x_i     (d_x),
    .ts_i    (ts_r),
    .out_ctl (b_ctl),
    .vel_o   (vel),
    .pos_o   (pos)
  );

  assign out_tvalid = b_ctl.vld;
  assign out_tuser  = b_ctl.zmass;

  if (VW <= VEC_FIELD_WIDTH) begin : g_out_pad
    assign out_tdata = {{(VEC_FIELD_WIDTH-VW){1'b0}}, pos,
                        {(VEC_FIELD_WIDTH-VW){1'b0}}, vel};
  end else begin : g_out_cut
    assign out_tdata = {pos[VEC_FIELD_WIDTH-1:0], vel[VEC_FIELD_WIDTH-1:0]};
  end

  // A configuration beat lands in the time step register on the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> ts_r == $past(cfg_data))
    else $error("time step write lost");

endmodule
